>>> rtl/record_fifo_with_high_water_mark_unit_macros.svh
// ----------------------------------------------------------------------------
// record fifo with high-water mark - assertion macros
// shared property forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef RECORD_FIFO_WITH_HIGH_WATER_MARK_UNIT_MACROS_SVH
`define RECORD_FIFO_WITH_HIGH_WATER_MARK_UNIT_MACROS_SVH

// same-cycle implication
`define RFIFO_HWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rfifo_hwm: same-cycle check failed");

// next-cycle implication
`define RFIFO_HWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rfifo_hwm: next-cycle check failed");

`endif

>>> rtl/rfifo_hwm_pkg.sv
// ----------------------------------------------------------------------------
// rfifo_hwm_pkg
// codes, widths and controller/datapath bundles of the record fifo
// ----------------------------------------------------------------------------
package rfifo_hwm_pkg;

    localparam int CFG_IW  = 8;
    localparam int CFG_DW  = 5;
    localparam int LEN_W   = 8;
    localparam int DATA_W  = 64;
    localparam int RLEN_W  = 4;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;
    localparam int BYTES_W = 4;

    localparam logic [CFG_IW-1:0] REG_RECORD_BYTES = 8'd0;
    localparam logic [CFG_IW-1:0] REG_SLOT_COUNT   = 8'd1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SIZE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

endpackage

>>> rtl/rfifo_hwm_ram.sv
// ----------------------------------------------------------------------------
// rfifo_hwm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rfifo_hwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rfifo_hwm_ctrl.sv
// ----------------------------------------------------------------------------
// rfifo_hwm_ctrl
// sequencer: store clearing after reset, operation capture and execute
// ----------------------------------------------------------------------------
module rfifo_hwm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  rfifo_hwm_pkg::t_dp_stat i_stat,
    output rfifo_hwm_pkg::t_ctrl_cmd o_cmd,
    output logic                    o_busy,
    output logic                    o_cfg_ready,
    output logic                    o_valid
);

    import rfifo_hwm_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       n_valid;

    always_comb begin
        n_state       = r_state;
        n_valid       = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_valid    = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;

endmodule

>>> rtl/rfifo_hwm_dp.sv
// ----------------------------------------------------------------------------
// rfifo_hwm_dp
// record store lanes, queue pointers, counters, configuration and result regs
// ----------------------------------------------------------------------------
module rfifo_hwm_dp #(
    parameter int MAX_SLOTS        = 16,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  rfifo_hwm_pkg::t_ctrl_cmd                 i_cmd,
    output rfifo_hwm_pkg::t_dp_stat                  o_stat,
    input  logic                                     i_cfg_we,
    input  logic [rfifo_hwm_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [rfifo_hwm_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic                                     i_operation,
    input  logic [rfifo_hwm_pkg::LEN_W-1:0]          i_length,
    input  logic [rfifo_hwm_pkg::DATA_W-1:0]         i_data_in,
    output logic [rfifo_hwm_pkg::STAT_W-1:0]         o_status,
    output logic [rfifo_hwm_pkg::DATA_W-1:0]         o_data_out,
    output logic [rfifo_hwm_pkg::RLEN_W-1:0]         o_returned_length,
    output logic [rfifo_hwm_pkg::OCC_W-1:0]          o_occupancy,
    output logic [rfifo_hwm_pkg::OCC_W-1:0]          o_max_occupancy
);

    import rfifo_hwm_pkg::*;

    localparam int IW         = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW         = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS + 1) : 1;
    localparam int RST_SLOTS  = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
    localparam int LANES      = DATA_W / 8;

    logic [BYTES_W-1:0] r_eff_bytes, n_eff_bytes;
    logic [CW-1:0]      r_eff_slots, n_eff_slots;
    logic [IW-1:0]      r_oldest, n_oldest;
    logic [IW-1:0]      r_newest, n_newest;
    logic               r_empty, n_empty;
    logic [CW-1:0]      r_held, n_held;
    logic [CW-1:0]      r_hw, n_hw;
    logic [IW-1:0]      r_clr_addr;

    logic               r_op;
    logic [LEN_W-1:0]   r_len;
    logic [DATA_W-1:0]  r_data;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [DATA_W-1:0]  r_dout, n_dout;
    logic [RLEN_W-1:0]  r_rlen, n_rlen;

    logic [BYTES_W-1:0] cfg_bytes;
    logic [CW-1:0]      cfg_slots;
    logic [IW-1:0]      next_idx;
    logic [IW-1:0]      next_old;
    logic               push_wr;
    logic [DATA_W-1:0]  rd_word;
    logic [7:0]         rd_lane [MAX_RECORD_BYTES];

    // record store, one ram per byte lane
    for (genvar k = 0; k < MAX_RECORD_BYTES; k++) begin : g_lane
        logic       lane_we;
        logic [7:0] lane_wdata;
        assign lane_we    = i_cmd.clear_en | (push_wr & (r_len > LEN_W'(k)));
        assign lane_wdata = i_cmd.clear_en ? 8'd0 : r_data[8*k +: 8];
        rfifo_hwm_ram #(
            .WIDTH (8),
            .DEPTH (MAX_SLOTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we),
            .i_waddr (i_cmd.clear_en ? r_clr_addr : next_idx),
            .i_wdata (lane_wdata),
            .i_raddr (r_oldest),
            .o_rdata (rd_lane[k])
        );
    end

    for (genvar k = 0; k < LANES; k++) begin : g_mask
        if (k < MAX_RECORD_BYTES) begin : g_used
            assign rd_word[8*k +: 8] = (r_eff_bytes > BYTES_W'(k)) ? rd_lane[k] : 8'd0;
        end else begin : g_unused
            assign rd_word[8*k +: 8] = 8'd0;
        end
    end

    // configuration values clamped to their usable range
    always_comb begin
        if (i_cfg_data[BYTES_W-1:0] == '0) begin
            cfg_bytes = BYTES_W'(1);
        end else if (32'(i_cfg_data[BYTES_W-1:0]) > MAX_RECORD_BYTES) begin
            cfg_bytes = BYTES_W'(MAX_RECORD_BYTES);
        end else begin
            cfg_bytes = i_cfg_data[BYTES_W-1:0];
        end
        if (i_cfg_data == '0) begin
            cfg_slots = CW'(1);
        end else if (32'(i_cfg_data) > MAX_SLOTS) begin
            cfg_slots = CW'(MAX_SLOTS);
        end else begin
            cfg_slots = CW'(i_cfg_data);
        end
    end

    // circular successors of the two pointers
    assign next_idx = ((CW'(r_newest) + CW'(1)) == r_eff_slots) ? '0 : IW'(r_newest + 1'b1);
    assign next_old = ((CW'(r_oldest) + CW'(1)) == r_eff_slots) ? '0 : IW'(r_oldest + 1'b1);

    assign push_wr = i_cmd.exec && (r_op == OP_PUSH) && (r_len <= LEN_W'(r_eff_bytes))
                     && (r_empty || (next_idx != r_oldest));

    always_comb begin
        n_eff_bytes = r_eff_bytes;
        n_eff_slots = r_eff_slots;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_empty     = r_empty;
        n_held      = r_held;
        n_hw        = r_hw;
        n_status    = r_status;
        n_dout      = r_dout;
        n_rlen      = r_rlen;

        if (i_cfg_we) begin
            if (i_cfg_index == REG_RECORD_BYTES) begin
                n_eff_bytes = cfg_bytes;
            end else if (i_cfg_index == REG_SLOT_COUNT) begin
                n_eff_slots = cfg_slots;
                n_oldest    = '0;
                n_newest    = IW'(cfg_slots - CW'(1));
                n_empty     = 1'b1;
                n_held      = '0;
            end
        end

        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_dout   = '0;
            n_rlen   = '0;
            if (r_op == OP_PUSH) begin
                if (r_len > LEN_W'(r_eff_bytes)) begin
                    n_status = ST_SIZE;
                end else if (!r_empty && (next_idx == r_oldest)) begin
                    n_status = ST_LIMIT;
                end else begin
                    n_held   = r_held + CW'(1);
                    n_newest = next_idx;
                    if ((r_held + CW'(1)) > r_hw) begin
                        n_hw = r_held + CW'(1);
                    end
                    if (r_empty) begin
                        n_oldest = next_idx;
                        n_empty  = 1'b0;
                    end
                end
            end else begin
                if (r_len < LEN_W'(r_eff_bytes)) begin
                    n_status = ST_SIZE;
                end else if (r_empty) begin
                    n_status = ST_LIMIT;
                end else begin
                    n_dout = rd_word;
                    n_rlen = RLEN_W'(r_eff_bytes);
                    if (r_held != '0) begin
                        n_held = r_held - CW'(1);
                    end
                    if (r_oldest == r_newest) begin
                        n_empty = 1'b1;
                    end else begin
                        n_oldest = next_old;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_bytes <= BYTES_W'(MAX_RECORD_BYTES);
            r_eff_slots <= CW'(RST_SLOTS);
            r_oldest    <= '0;
            r_newest    <= IW'(RST_SLOTS - 1);
            r_empty     <= 1'b1;
            r_held      <= '0;
            r_hw        <= '0;
            r_clr_addr  <= '0;
        end else begin
            r_eff_bytes <= n_eff_bytes;
            r_eff_slots <= n_eff_slots;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_empty     <= n_empty;
            r_held      <= n_held;
            r_hw        <= n_hw;
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_len  <= i_length;
            r_data <= i_data_in;
        end
        r_status <= n_status;
        r_dout   <= n_dout;
        r_rlen   <= n_rlen;
    end

    assign o_stat.clear_last = (r_clr_addr == IW'(MAX_SLOTS - 1));

    assign o_status          = r_status;
    assign o_data_out        = r_dout;
    assign o_returned_length = r_rlen;
    assign o_occupancy       = OCC_W'(r_held);
    assign o_max_occupancy   = OCC_W'(r_hw);

endmodule

>>> rtl/record_fifo_with_high_water_mark_unit.sv
// ----------------------------------------------------------------------------
// record_fifo_with_high_water_mark_unit
// circular fifo of fixed-size records with occupancy and high-water reporting
//
//  channel   handshake                  payload
//  command   start / busy               i_operation, i_length, i_data_in
//  result    o_valid (one-cycle strobe) o_status, o_data_out, o_returned_length,
//                                       o_occupancy, o_max_occupancy
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  every operation runs as a capture, then one ram read-modify step;
//  the strobe follows in the next cycle; no new command is taken while busy is high
//  after reset the store is swept to zero with busy high
//  results cannot be held off; a result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`include "record_fifo_with_high_water_mark_unit_macros.svh"

module record_fifo_with_high_water_mark_unit #(
    parameter int MAX_SLOTS        = 16,
    parameter int MAX_RECORD_BYTES = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_operation,
    input  logic [rfifo_hwm_pkg::LEN_W-1:0]      i_length,
    input  logic [rfifo_hwm_pkg::DATA_W-1:0]     i_data_in,
    output logic                                 o_valid,
    output logic [rfifo_hwm_pkg::STAT_W-1:0]     o_status,
    output logic [rfifo_hwm_pkg::DATA_W-1:0]     o_data_out,
    output logic [rfifo_hwm_pkg::RLEN_W-1:0]     o_returned_length,
    output logic [rfifo_hwm_pkg::OCC_W-1:0]      o_occupancy,
    output logic [rfifo_hwm_pkg::OCC_W-1:0]      o_max_occupancy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rfifo_hwm_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [rfifo_hwm_pkg::CFG_DW-1:0]     i_cfg_data
);

    import rfifo_hwm_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      cfg_we;

    assign cfg_we = i_cfg_valid & o_cfg_ready;

    rfifo_hwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid)
    );

    rfifo_hwm_dp #(
        .MAX_SLOTS        (MAX_SLOTS),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_length          (i_length),
        .i_data_in         (i_data_in),
        .o_status          (o_status),
        .o_data_out        (o_data_out),
        .o_returned_length (o_returned_length),
        .o_occupancy       (o_occupancy),
        .o_max_occupancy   (o_max_occupancy)
    );

    // a transfer on the command side always leads to busy in the next cycle
    `RFIFO_HWM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // one strobe per operation
    `RFIFO_HWM_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    // occupancy never above the high-water mark
    `RFIFO_HWM_ASSERT_IMP(a_hwm_bound, i_clk, i_rst_n, o_valid, o_occupancy <= o_max_occupancy)
    // failed operations carry no record
    `RFIFO_HWM_ASSERT_IMP(a_fail_empty, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_returned_length == '0) && (o_data_out == '0))

endmodule
